FILE: design/ilse_pkg.sv
// Shared types and constants of the indexed list stack engine.
package ilse_pkg;

  // Widest cell index the row supports (up to 4096 entries).
  localparam int unsigned IDX_W = 12;
  // Cells per first-level group of the read reduction tree.
  localparam int unsigned READ_GROUP = 64;

  typedef enum logic [3:0] {
    KIND_GET     = 4'd0,
    KIND_SET     = 4'd1,
    KIND_INSERT  = 4'd2,
    KIND_DELETE  = 4'd3,
    KIND_APPEND  = 4'd4,
    KIND_PREPEND = 4'd5,
    KIND_PEEK    = 4'd6,
    KIND_ADD_TOP = 4'd7,
    KIND_POP     = 4'd8,
    KIND_DROP    = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_WRITE      = 3'd1,
    CELL_ADD        = 3'd2,
    CELL_SHIFT_UP   = 3'd3,
    CELL_SHIFT_DOWN = 3'd4
  } cell_op_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   widx;
    logic               rd_en;
    logic [IDX_W-1:0]   ridx;
    logic [31:0]        value;
  } cell_ctrl_t;

  // Result fields that travel alongside the read reduction.
  typedef struct packed {
    logic [8:0] new_position;
    logic [8:0] entry_count;
    status_e    status;
  } rsp_meta_t;

endpackage

FILE: design/ilse_req_if.sv
// Request channel: operation kind, position and word.
interface ilse_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [8:0]         position;
  logic signed [31:0] item_value;

  modport source (output valid, kind, position, item_value, input ready);
  modport sink (input valid, kind, position, item_value, output ready);
endinterface

FILE: design/ilse_rsp_if.sv
// Response channel: read word, new position, entry count and status.
interface ilse_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [8:0]         new_position;
  logic [8:0]         entry_count;
  logic [1:0]         status;

  modport source (output valid, read_value, new_position, entry_count, status, input ready);
  modport sink (input valid, read_value, new_position, entry_count, status, output ready);
endinterface

FILE: design/ilse_cell.sv
// One list entry: holds a word, shifts with its neighbors, offers it for reads.
module ilse_cell import ilse_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  cell_ctrl_t  ctrl_i,
  input  logic [31:0] left_i,
  input  logic [31:0] right_i,
  output logic [31:0] data_o,
  output logic [31:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [31:0] data_q, data_d;
  logic [31:0] rd_q, rd_d;
  logic        here;

  assign here = (ctrl_i.widx == MyIdx);

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CELL_WRITE: begin
        if (here) data_d = ctrl_i.value;
      end
      CELL_ADD: begin
        if (here) data_d = data_q + ctrl_i.value;
      end
      CELL_SHIFT_UP: begin
        if (MyIdx > ctrl_i.widx) data_d = left_i;
        else if (here) data_d = ctrl_i.value;
      end
      CELL_SHIFT_DOWN: begin
        if (MyIdx >= ctrl_i.widx) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  // Only the addressed cell contributes to the read reduction.
  assign rd_d = (ctrl_i.rd_en && ctrl_i.ridx == MyIdx) ? data_q : '0;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (en_i) rd_q <= rd_d;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

FILE: design/ilse_read_tree.sv
// Two-level registered OR tree that collects the word read out of the cell row.
module ilse_read_tree import ilse_pkg::*; #(
  parameter int unsigned N = 2
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] data_i [N],
  output logic [31:0] data_o
);

  localparam int unsigned NumGrp = (N + READ_GROUP - 1) / READ_GROUP;

  logic [31:0] grp_q [NumGrp];
  logic [31:0] grp_d [NumGrp];
  logic [31:0] sum_d;
  logic [31:0] sum_q;

  always_comb begin
    int idx;
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < READ_GROUP; j++) begin
        idx = g * READ_GROUP + j;
        if (idx < N) grp_d[g] = grp_d[g] | data_i[idx];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NumGrp; g++) begin
      sum_d = sum_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
      sum_q <= sum_d;
    end
  end

  assign data_o = sum_q;

endmodule

FILE: design/indexed_list_stack_engine.sv
// Each response is registered in the s1, s2 and output stages once accepted.
// Throughput: one request per cycle while the response side keeps taking;
//   the response register and the two read-tree stages stall together.
// Each cell updates at the accept edge, so insert and delete shift all at once.
// Reset clears the entry count and the pipeline valids; entry words are not
//   cleared, and no word is read before it was written.
module indexed_list_stack_engine import ilse_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilse_req_if.sink   req_i,
  ilse_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Compare width covers both the count and the 9-bit position field.
  localparam int unsigned WW = (CW > 9) ? CW : 9;

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the response stalls.
  // ---------------------------------------------------------------------------
  logic      pipe_en;
  logic      accept;
  logic      s1_valid_q, s2_valid_q, out_valid_q;
  rsp_meta_t s1_meta_q, s2_meta_q, out_meta_q;
  rsp_meta_t meta_d;

  assign pipe_en     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = pipe_en;
  assign accept      = req_i.valid && pipe_en;

  // ---------------------------------------------------------------------------
  // Decode: bounds checks against the held count and one command for the row.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] count_q, count_d, count_next;
  logic [WW-1:0] pos_w, cnt_w;
  logic          pos_ok, is_full, is_empty;
  cell_ctrl_t    cmd, ctrl;
  status_e       st;
  logic [8:0]    new_pos;

  assign pos_w    = WW'(req_i.position);
  assign cnt_w    = WW'(count_q);
  assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.widx   = '0;
    cmd.rd_en  = 1'b0;
    cmd.ridx   = '0;
    cmd.value  = req_i.item_value;
    st         = ST_OK;
    new_pos    = '0;
    count_next = count_q;
    unique case (kind_e'(req_i.kind))
      KIND_GET: begin
        if (pos_ok) begin
          cmd.rd_en = 1'b1;
          cmd.ridx  = IDX_W'(pos_w - WW'(1));
        end else begin
          st = ST_RANGE;
        end
      end
      KIND_SET: begin
        if (pos_ok) begin
          cmd.op   = CELL_WRITE;
          cmd.widx = IDX_W'(pos_w - WW'(1));
        end else begin
          st = ST_RANGE;
        end
      end
      KIND_INSERT: begin
        if (!pos_ok) begin
          st = ST_RANGE;
        end else if (is_full) begin
          st = ST_FULL;
        end else begin
          cmd.op     = CELL_SHIFT_UP;
          cmd.widx   = IDX_W'(pos_w - WW'(1));
          count_next = count_q + CW'(1);
        end
      end
      KIND_DELETE: begin
        if (pos_ok) begin
          cmd.op     = CELL_SHIFT_DOWN;
          cmd.widx   = IDX_W'(pos_w - WW'(1));
          count_next = count_q - CW'(1);
        end else begin
          st = ST_RANGE;
        end
      end
      KIND_APPEND, KIND_PREPEND: begin
        if (is_full) begin
          st = ST_FULL;
        end else if (kind_e'(req_i.kind) == KIND_APPEND || is_empty) begin
          // Prepend to an empty list behaves as append.
          cmd.op     = CELL_WRITE;
          cmd.widx   = IDX_W'(cnt_w);
          count_next = count_q + CW'(1);
          new_pos    = 9'(cnt_w + WW'(1));
        end else begin
          cmd.op     = CELL_SHIFT_UP;
          cmd.widx   = '0;
          count_next = count_q + CW'(1);
        end
      end
      KIND_PEEK: begin
        if (pos_w >= cnt_w) begin
          st = ST_RANGE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.ridx  = IDX_W'(cnt_w - pos_w - WW'(1));
        end
      end
      KIND_ADD_TOP: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          cmd.op   = CELL_ADD;
          cmd.widx = IDX_W'(cnt_w - WW'(1));
        end
      end
      KIND_POP: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ridx   = IDX_W'(cnt_w - WW'(1));
          count_next = count_q - CW'(1);
        end
      end
      KIND_DROP: begin
        if (pos_w > cnt_w) begin
          st = ST_RANGE;
        end else begin
          count_next = CW'(cnt_w - pos_w);
        end
      end
      default: begin
        // Unused kinds: no operation, status ok.
        st = ST_OK;
      end
    endcase
  end

  // The row only sees a command on an accepted request.
  always_comb begin
    ctrl = cmd;
    if (!accept) begin
      ctrl.op    = CELL_HOLD;
      ctrl.rd_en = 1'b0;
    end
  end

  assign count_d             = accept ? count_next : count_q;
  assign meta_d.new_position = new_pos;
  assign meta_d.entry_count  = 9'(count_next);
  assign meta_d.status       = st;

  // ---------------------------------------------------------------------------
  // Cell row: each cell sees its left and right neighbors.
  // ---------------------------------------------------------------------------
  logic [31:0] cell_data [DEPTH];
  logic [31:0] cell_rd   [DEPTH];
  logic [31:0] rd_word;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ilse_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  ilse_read_tree #(
    .N (DEPTH)
  ) u_read_tree (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .data_i (cell_rd),
    .data_o (rd_word)
  );

  // ---------------------------------------------------------------------------
  // State and response pipeline.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (pipe_en) begin
        s1_valid_q  <= accept;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_meta_q  <= meta_d;
      s2_meta_q  <= s1_meta_q;
      out_meta_q <= s2_meta_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_value   = rd_word;
  assign rsp_o.new_position = out_meta_q.new_position;
  assign rsp_o.entry_count  = out_meta_q.entry_count;
  assign rsp_o.status       = out_meta_q.status;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_error_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && st != ST_OK |=> $stable(count_q))
    else $error("failed request changed the entry count");

  a_error_zero_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_meta_q.status != ST_OK |-> rd_word == '0)
    else $error("failed request returned a nonzero word");

  a_newpos_is_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_meta_q.new_position != '0
      |-> out_meta_q.new_position == out_meta_q.entry_count)
    else $error("appended position differs from entry count");
`endif

endmodule
